// ===== sv/bfiq_pkg.sv =====
package bfiq_pkg;

    localparam int unsigned FILTER_BITS_DEF   = 65536;
    localparam int unsigned MAX_KEY_WORDS_DEF = 16;
    localparam int unsigned MAX_HASHES_DEF    = 16;

    localparam logic [31:0] MM_MUL = 32'h5bd1e995;

    localparam logic [31:0] SEED_RST  = 32'd0;
    localparam logic [4:0]  NHASH_RST = 5'd4;
    localparam logic [16:0] NBITS_RST = 17'd65536;

    typedef enum logic [1:0] {
        CFG_HASH_SEED  = 2'd0,
        CFG_NUM_HASHES = 2'd1,
        CFG_NUM_BITS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic        op;
        logic [31:0] key_word;
        logic [2:0]  word_bytes;
        logic        last;
    } t_in_beat;

    typedef struct packed {
        logic        present;
        logic [31:0] key_count;
        logic        key_too_long;
    } t_out_beat;

endpackage

// ===== sv/bloom_filter_insert_query_top.sv =====
// Bloom filter with insert and query. Key words stream in on the input channel and are
// buffered while the block is idle. On the last word the block runs num_hashes (capped at
// MAX_HASHES) chained MurmurHash2 passes on one shared 32x32 multiplier. Each pass runs
// S_INIT, then S_WORD, S_W2 and S_W3 per full key word, then S_TAIL for a partial last word,
// then S_FIN and S_MIX. It then runs a bit-serial remainder by num_bits and a filter memory
// access in S_MEM (followed by S_CHK for a query). A query stops at the first clear bit.
// After reset the filter memory is swept to zero, one bit a cycle, before the first word is
// taken; configuration writes are taken at all times and must only arrive while the block
// is idle.
module bloom_filter_insert_query_top #(
    parameter int FILTER_BITS   = bfiq_pkg::FILTER_BITS_DEF,
    parameter int MAX_KEY_WORDS = bfiq_pkg::MAX_KEY_WORDS_DEF,
    parameter int MAX_HASHES    = bfiq_pkg::MAX_HASHES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bfiq_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output bfiq_pkg::t_out_beat o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    import bfiq_pkg::*;

    localparam int AW = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;
    localparam int IW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int WW = $clog2(MAX_KEY_WORDS + 1);
    localparam int LW = $clog2(MAX_KEY_WORDS * 4 + 1);
    localparam logic [LW-1:0] LEN_FULL = LW'(MAX_KEY_WORDS * 4);
    localparam logic [5:0]    MAXH = 6'(MAX_HASHES);
    localparam logic [17:0]   FB_CAP = (FILTER_BITS > 131071) ? 18'd131071 :
                                       18'(FILTER_BITS);
    localparam logic [AW-1:0] CLR_LAST = AW'(FILTER_BITS - 1);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_INIT  = 13'b0000000000100,
        S_WORD  = 13'b0000000001000,
        S_W2    = 13'b0000000010000,
        S_W3    = 13'b0000000100000,
        S_TAIL  = 13'b0000001000000,
        S_FIN   = 13'b0000010000000,
        S_MIX   = 13'b0000100000000,
        S_DIV   = 13'b0001000000000,
        S_MEM   = 13'b0010000000000,
        S_CHK   = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } t_state;

    t_state      r_state;
    logic [31:0] r_seed;
    logic [4:0]  r_nhash;
    logic [16:0] r_nbits;
    logic [LW-1:0] r_key_len;
    logic        r_ovf;
    logic [31:0] r_cnt;
    logic        r_op;
    logic        r_present;
    logic [5:0]  r_hcnt;
    logic [WW-1:0] r_widx;
    logic [31:0] r_h;
    logic [31:0] r_k;
    logic [31:0] r_dq;
    logic [17:0] r_rem;
    logic [4:0]  r_bcnt;
    logic [AW-1:0] r_clr;
    logic        r_out_valid;
    t_out_beat   r_out;

    logic [5:0]  k_eff;
    logic [17:0] m_eff;
    logic [2:0]  wb_sat;
    logic        in_acc;
    logic        words_left;
    logic [31:0] cur_word;
    logic [31:0] tail_bits;
    logic [31:0] mul_a;
    logic [31:0] prod;
    logic [17:0] trial;
    logic        last_hash;
    logic        out_load;
    logic [AW-1:0] bit_addr;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic        ram_rdata;
    logic [WW-1:0] widx_inc;
    logic        buf_we;
    logic [IW-1:0] buf_waddr;
    logic [IW-1:0] buf_raddr;

    assign k_eff = ({1'b0, r_nhash} > MAXH) ? MAXH : {1'b0, r_nhash};
    assign m_eff = (r_nbits == 17'd0) ? 18'd1 :
                   (({1'b0, r_nbits} > FB_CAP) ? FB_CAP : {1'b0, r_nbits});
    assign wb_sat = (i_in_data.word_bytes > 3'd4) ? 3'd4 : i_in_data.word_bytes;
    assign in_acc = i_in_valid && o_in_ready;
    assign words_left = LW'(r_widx) < (r_key_len >> 2);
    assign widx_inc = r_widx + WW'(1);
    assign last_hash = (r_hcnt + 6'd1) == k_eff;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign trial = {r_rem[16:0], r_dq[31]};
    assign bit_addr = AW'(r_rem);

    always_comb begin
        unique case (r_key_len[1:0])
            2'd3:    tail_bits = cur_word & 32'h00ffffff;
            2'd2:    tail_bits = cur_word & 32'h0000ffff;
            2'd1:    tail_bits = cur_word & 32'h000000ff;
            default: tail_bits = 32'h0;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_WORD:  mul_a = cur_word;
            S_W2:    mul_a = r_k ^ (r_k >> 24);
            S_W3:    mul_a = r_h;
            S_TAIL:  mul_a = r_h ^ tail_bits;
            S_FIN:   mul_a = r_h ^ (r_h >> 13);
            default: mul_a = r_h;
        endcase
    end

    assign prod = mul_a * MM_MUL;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_seed      <= SEED_RST;
            r_nhash     <= NHASH_RST;
            r_nbits     <= NBITS_RST;
            r_key_len   <= '0;
            r_ovf       <= 1'b0;
            r_cnt       <= 32'd0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_HASH_SEED:  r_seed  <= i_cfg_data;
                    CFG_NUM_HASHES: r_nhash <= i_cfg_data[4:0];
                    CFG_NUM_BITS:   r_nbits <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_out_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_key_len >= LEN_FULL) begin
                            if (!i_in_data.last || wb_sat != 3'd0) begin
                                r_ovf <= 1'b1;
                            end
                        end else if (!i_in_data.last) begin
                            r_key_len <= r_key_len + LW'(4);
                        end else begin
                            r_key_len <= r_key_len + LW'(wb_sat);
                        end
                        if (i_in_data.last) begin
                            r_op      <= i_in_data.op;
                            r_present <= 1'b1;
                            r_hcnt    <= 6'd0;
                            r_state   <= (k_eff == 6'd0) ? S_DONE : S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    r_h     <= ((r_hcnt == 6'd0) ? r_seed : r_h) ^ 32'(r_key_len);
                    r_widx  <= '0;
                    r_state <= S_WORD;
                end
                S_WORD: begin
                    if (words_left) begin
                        r_k     <= prod;
                        r_state <= S_W2;
                    end else if (r_key_len[1:0] != 2'd0) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_W2: begin
                    r_k     <= prod;
                    r_state <= S_W3;
                end
                S_W3: begin
                    r_h     <= prod ^ r_k;
                    r_widx  <= widx_inc;
                    r_state <= S_WORD;
                end
                S_TAIL: begin
                    r_h     <= prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_h     <= prod;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_h     <= r_h ^ (r_h >> 15);
                    r_dq    <= r_h ^ (r_h >> 15);
                    r_rem   <= 18'd0;
                    r_bcnt  <= 5'd0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= (trial >= m_eff) ? (trial - m_eff) : trial;
                    r_dq   <= r_dq << 1;
                    r_bcnt <= r_bcnt + 5'd1;
                    if (r_bcnt == 5'd31) begin
                        r_state <= S_MEM;
                    end
                end
                S_MEM: begin
                    if (!r_op) begin
                        r_state <= S_CHK;
                    end else if (last_hash) begin
                        r_state <= S_DONE;
                    end else begin
                        r_hcnt  <= r_hcnt + 6'd1;
                        r_state <= S_INIT;
                    end
                end
                S_CHK: begin
                    if (!ram_rdata) begin
                        r_present <= 1'b0;
                        r_state   <= S_DONE;
                    end else if (last_hash) begin
                        r_state <= S_DONE;
                    end else begin
                        r_hcnt  <= r_hcnt + 6'd1;
                        r_state <= S_INIT;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_valid <= 1'b1;
                        r_key_len   <= '0;
                        r_ovf       <= 1'b0;
                        if (r_op) begin
                            r_cnt <= r_cnt + 32'd1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.present      <= r_op ? 1'b1 : r_present;
            r_out.key_count    <= r_op ? (r_cnt + 32'd1) : r_cnt;
            r_out.key_too_long <= r_ovf;
        end
    end

    assign buf_we    = in_acc && r_key_len < LEN_FULL && (!i_in_data.last || wb_sat != 3'd0);
    assign buf_waddr = IW'(r_key_len >> 2);
    assign buf_raddr = (r_state == S_INIT) ? '0 :
                       (r_state == S_W3) ? widx_inc[IW-1:0] : r_widx[IW-1:0];

    bfiq_ram #(
        .WIDTH (32),
        .DEPTH (MAX_KEY_WORDS)
    ) u_key_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (i_in_data.key_word),
        .i_raddr (buf_raddr),
        .o_rdata (cur_word)
    );

    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_MEM) && r_op);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : bit_addr;

    bfiq_ram #(
        .WIDTH (1),
        .DEPTH (FILTER_BITS)
    ) u_filter (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_state == S_MEM),
        .i_raddr (bit_addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV || r_state == S_MEM) |-> r_rem < m_eff)
        else $error("remainder not below modulus");
    a_hash_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> r_hcnt < k_eff)
        else $error("hash count past limit");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_len <= LEN_FULL)
        else $error("key length past buffer");
    a_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_out_valid && r_key_len == '0 && !r_ovf && r_state == S_IDLE))
        else $error("result load did not close key");
`endif

endmodule

// ===== sv/bfiq_ram.sv =====
module bfiq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== verif/tb_bloom_filter_insert_query_top.sv =====
`timescale 1ns / 100ps

module tb_bloom_filter_insert_query_top;
    import bfiq_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 300000;
    localparam int unsigned SETTLE_CYCLES  = 200;
    localparam int unsigned POOL_DEPTH     = 64;
    localparam int unsigned POOL_WORDS     = 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_beat    in_data = '0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    t_out_beat   o_out_data;
    logic        o_cfg_ready;

    bloom_filter_insert_query_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // model state
    bit          filt_mem [0:FILTER_BITS_DEF-1];
    logic [31:0] key_words [0:MAX_KEY_WORDS_DEF-1];
    int unsigned key_len;
    logic        key_ovf;
    logic [31:0] ins_count;
    logic [31:0] seed_reg;
    logic [4:0]  nhash_reg;
    logic [16:0] nbits_reg;

    t_in_beat    word_q [$];
    t_out_beat   answers_q [$];
    logic        idle_on = 1'b1;
    int unsigned fail_cnt;
    int unsigned beats_in;
    int unsigned keys_done;
    int unsigned hits_seen;
    int unsigned ovf_seen;
    int unsigned idle_cycles;

    logic [31:0] pool_w [0:POOL_DEPTH-1][0:POOL_WORDS-1];
    int unsigned pool_n [0:POOL_DEPTH-1];
    logic [2:0]  pool_b [0:POOL_DEPTH-1];
    int unsigned pool_fill;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] key_byte_at(int unsigned i);
        return 8'(key_words[(i >> 2) % MAX_KEY_WORDS_DEF] >> (8 * (i & 3)));
    endfunction

    function automatic logic [31:0] murmur_chain(int unsigned len, logic [31:0] seed);
        logic [31:0] h;
        logic [31:0] k;
        int unsigned pos;
        int unsigned rest;
        h = seed ^ len;
        pos = 0;
        rest = len;
        while (rest >= 4) begin
            k = {key_byte_at(pos + 3), key_byte_at(pos + 2), key_byte_at(pos + 1),
                 key_byte_at(pos)};
            k = k * MM_MUL;
            k = k ^ (k >> 24);
            k = k * MM_MUL;
            h = h * MM_MUL;
            h = h ^ k;
            pos += 4;
            rest -= 4;
        end
        if (rest == 3) h = h ^ (32'(key_byte_at(pos + 2)) << 16);
        if (rest >= 2) h = h ^ (32'(key_byte_at(pos + 1)) << 8);
        if (rest >= 1) begin
            h = h ^ 32'(key_byte_at(pos));
            h = h * MM_MUL;
        end
        h = h ^ (h >> 13);
        h = h * MM_MUL;
        h = h ^ (h >> 15);
        return h;
    endfunction

    function automatic void buffer_word(logic [31:0] w, int unsigned nb);
        if ((key_len >> 2) >= MAX_KEY_WORDS_DEF) begin
            key_ovf = 1'b1;
        end else begin
            key_words[key_len >> 2] = w;
            key_len += nb;
        end
    endfunction

    function automatic void predict_lookup(t_in_beat b);
        int unsigned nb;
        int unsigned kh;
        int unsigned m;
        logic [31:0] h;
        int unsigned idx;
        t_out_beat r;
        if (!b.last) begin
            buffer_word(b.key_word, 4);
            return;
        end
        nb = (b.word_bytes > 4) ? 4 : b.word_bytes;
        if (nb > 0) buffer_word(b.key_word, nb);
        kh = (nhash_reg > MAX_HASHES_DEF) ? MAX_HASHES_DEF : nhash_reg;
        m = nbits_reg;
        if (m == 0) m = 1;
        if (m > FILTER_BITS_DEF) m = FILTER_BITS_DEF;
        r.present = 1'b1;
        h = seed_reg;
        for (int unsigned i = 0; i < kh; i++) begin
            h = murmur_chain(key_len, h);
            idx = h % m;
            if (b.op) begin
                filt_mem[idx] = 1'b1;
            end else if (!filt_mem[idx]) begin
                r.present = 1'b0;
                break;
            end
        end
        if (b.op) ins_count = ins_count + 32'd1;
        r.key_count = ins_count;
        r.key_too_long = key_ovf;
        if (!b.op && r.present) hits_seen++;
        if (key_ovf) ovf_seen++;
        answers_q.push_back(r);
        key_len = 0;
        key_ovf = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                predict_lookup(in_data);
                beats_in++;
            end
            if (!in_valid || o_in_ready) begin
                if (word_q.size() > 0 && !(idle_on && $urandom_range(99) < 32)) begin
                    in_data <= word_q.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                keys_done++;
                if (answers_q.size() == 0) begin
                    $error("result beat with no expectation pending");
                    fail_cnt++;
                end else begin
                    want = answers_q.pop_front();
                    if (o_out_data.present !== want.present) begin
                        $error("present: expected %0d, got %0d", want.present,
                               o_out_data.present);
                        fail_cnt++;
                    end
                    if (o_out_data.key_count !== want.key_count) begin
                        $error("key_count: expected %0d, got %0d", want.key_count,
                               o_out_data.key_count);
                        fail_cnt++;
                    end
                    if (o_out_data.key_too_long !== want.key_too_long) begin
                        $error("key_too_long: expected %0d, got %0d", want.key_too_long,
                               o_out_data.key_too_long);
                        fail_cnt++;
                    end
                end
            end
            out_ready <= !(idle_on && $urandom_range(99) < 32);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", answers_q.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] d);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HASH_SEED:  seed_reg = d;
            CFG_NUM_HASHES: nhash_reg = d[4:0];
            CFG_NUM_BITS:   nbits_reg = d[16:0];
            default: ;
        endcase
    endtask

    task automatic set_filter(logic [31:0] s, logic [31:0] nh, logic [31:0] nb);
        cfg_write(CFG_HASH_SEED, s);
        cfg_write(CFG_NUM_HASHES, nh);
        cfg_write(CFG_NUM_BITS, nb);
    endtask

    task automatic drain;
        @(posedge i_clk);
        while (word_q.size() > 0 || in_valid || answers_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // push pool entry p as a key with the given op
    function automatic void push_key(int unsigned p, logic op);
        t_in_beat b;
        for (int unsigned i = 0; i <= pool_n[p]; i++) begin
            b.op = (i == pool_n[p]) ? op : 1'($urandom_range(1));
            b.key_word = pool_w[p][i];
            b.last = (i == pool_n[p]);
            b.word_bytes = b.last ? pool_b[p] : 3'($urandom_range(7));
            word_q.push_back(b);
        end
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned make_key(int unsigned nw, logic [2:0] lb);
        int unsigned p;
        p = pool_fill % POOL_DEPTH;
        pool_fill++;
        pool_n[p] = nw;
        pool_b[p] = lb;
        for (int unsigned i = 0; i <= nw; i++) pool_w[p][i] = rand_word();
        return p;
    endfunction

    // most keys short; a few overflow the buffer; queries often replay old keys
    function automatic void random_keys(int unsigned n_beats, int unsigned max_nw);
        int unsigned target;
        int unsigned p;
        int unsigned nw;
        logic [2:0] lb;
        logic op;
        target = word_q.size() + n_beats;
        while (word_q.size() < target) begin
            op = 1'($urandom_range(1));
            if (!op && pool_fill > 0 && $urandom_range(99) < 55) begin
                p = $urandom_range(((pool_fill < POOL_DEPTH) ? pool_fill : POOL_DEPTH) - 1);
            end else begin
                nw = ($urandom_range(99) < 3) ? $urandom_range(19, 16) : $urandom_range(max_nw);
                lb = ($urandom_range(99) < 10) ? 3'($urandom_range(7, 5)) :
                     3'($urandom_range(4));
                p = make_key(nw, lb);
            end
            push_key(p, op);
        end
    endfunction

    initial begin
        int unsigned p;
        int unsigned q;
        for (int unsigned i = 0; i < FILTER_BITS_DEF; i++) filt_mem[i] = 1'b0;
        key_len = 0;
        key_ovf = 1'b0;
        ins_count = '0;
        seed_reg = SEED_RST;
        nhash_reg = NHASH_RST;
        nbits_reg = NBITS_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        p = make_key(2, 3'd4);
        push_key(p, 1'b1);
        push_key(p, 1'b0);
        push_key(make_key(1, 3'd3), 1'b0);
        push_key(make_key(0, 3'd0), 1'b1);
        push_key(make_key(0, 3'd0), 1'b0);
        q = make_key(0, 3'd1);
        pool_w[q][0] = 32'h0;
        push_key(q, 1'b1);
        q = make_key(1, 3'd2);
        pool_w[q][0] = 32'hffff_ffff;
        pool_w[q][1] = 32'hffff_ffff;
        push_key(q, 1'b1);
        push_key(make_key(0, 3'd7), 1'b1);
        push_key(make_key(0, 3'd5), 1'b0);
        push_key(make_key(3, 3'd6), 1'b1);
        drain();

        set_filter(32'hffff_ffff, 32'd1, 32'd1);
        @(negedge i_clk);
        random_keys(100, 4);
        drain();

        set_filter($urandom, 32'd16, 32'd65536);
        idle_on = 1'b0;
        @(negedge i_clk);
        random_keys(60, 3);
        drain();
        idle_on = 1'b1;

        set_filter($urandom, 32'd0, 32'd0);
        @(negedge i_clk);
        random_keys(50, 4);
        drain();

        set_filter(32'h0, 32'd31, 32'h1_ffff);
        @(negedge i_clk);
        random_keys(40, 2);
        drain();

        set_filter($urandom, 32'($urandom_range(6, 1)), 32'($urandom_range(200, 8)));
        @(negedge i_clk);
        random_keys(450, 4);
        drain();

        set_filter($urandom, 32'd3, 32'($urandom_range(65536, 4096)));
        @(negedge i_clk);
        random_keys(200, 4);
        drain();
        idle_on = 1'b0;
        @(negedge i_clk);
        random_keys(200, 4);
        drain();
        idle_on = 1'b1;

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d key words, %0d keys checked, %0d inserts", beats_in,
                 keys_done, ins_count);
        $display("queries found present: %0d, truncated keys: %0d", hits_seen, ovf_seen);
        if (fail_cnt == 0 && answers_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            if (answers_q.size() != 0) $error("%0d expected results never arrived",
                                              answers_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bfiq_pkg.sv
sv/bfiq_ram.sv
sv/bloom_filter_insert_query_top.sv
verif/tb_bloom_filter_insert_query_top.sv
